>>> sv/ipc_endpoint_mailbox_top_assert.svh
// Assertion macros for the endpoint mailbox.
`ifndef IPC_ENDPOINT_MAILBOX_TOP_ASSERT_SVH
`define IPC_ENDPOINT_MAILBOX_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IEM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
`define IEM_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`else
`define IEM_ASSERT(lbl, prop)
`define IEM_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

>>> sv/ipc_ep_pkg.sv
`timescale 1ns / 1ps
package ipc_ep_pkg;

	localparam int EP_W   = 8;
	localparam int WORD_W = 64;
	localparam int PID_W  = 15;
	localparam int SID_W  = 16;

	localparam logic [2:0] CMD_CREATE   = 3'd0;
	localparam logic [2:0] CMD_SEND     = 3'd1;
	localparam logic [2:0] CMD_RECV     = 3'd2;
	localparam logic [2:0] CMD_TRY_RECV = 3'd3;
	localparam logic [2:0] CMD_NOTIFY   = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ERR   = 2'd1;
	localparam logic [1:0] STAT_BLOCK = 2'd2;

	typedef enum logic [1:0] {
		SLOT_FREE      = 2'd0,
		SLOT_IDLE      = 2'd1,
		SLOT_SEND_WAIT = 2'd2,
		SLOT_RECV_WAIT = 2'd3
	} slot_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic [2:0]              command;
		logic [EP_W-1:0]         endpoint;
		logic [PID_W-1:0]        owner_id;
		logic [WORD_W-1:0]       msg_word0;
		logic [WORD_W-1:0]       msg_word1;
		logic [WORD_W-1:0]       msg_word2;
		logic [WORD_W-1:0]       msg_word3;
		logic signed [SID_W-1:0] msg_sender;
		logic [PID_W-1:0]        caller_pid;
		logic [PID_W-1:0]        caller_tid;
		logic [WORD_W-1:0]       notify_bits;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic [EP_W-1:0]         new_endpoint;
		logic [WORD_W-1:0]       out_word0;
		logic [WORD_W-1:0]       out_word1;
		logic [WORD_W-1:0]       out_word2;
		logic [WORD_W-1:0]       out_word3;
		logic signed [SID_W-1:0] out_sender;
		logic                    wake_valid;
		logic [PID_W-1:0]        wake_tid;
	} out_item_t;

	typedef struct packed {
		logic            re;
		logic            ent_we;
		logic            msg_we;
		logic [EP_W-1:0] addr;
	} mem_ctl_t;

endpackage

>>> sv/ipc_ep_ram.sv
`timescale 1ns / 1ps
module ipc_ep_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/ipc_ep_ctrl.sv
`timescale 1ns / 1ps
`include "ipc_endpoint_mailbox_top_assert.svh"
module ipc_ep_ctrl import ipc_ep_pkg::*; #(
	parameter int NUM_ENDPOINTS = 64,
	parameter int ID_BITS       = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  in_item_t                        req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output out_item_t                       rsp,
	output mem_ctl_t                        mc,
	output logic [2+3*ID_BITS+WORD_W-1:0]   ent_wdata,
	input  logic [2+3*ID_BITS+WORD_W-1:0]   ent_rdata,
	output logic [4*WORD_W+ID_BITS-1:0]     msg_wdata,
	input  logic [4*WORD_W+ID_BITS-1:0]     msg_rdata
);

	localparam int CW    = $clog2(NUM_ENDPOINTS + 1);
	localparam int CMP_W = EP_W + 1;

	fsm_t      state_q, state_d;
	in_item_t  req_s1;
	out_item_t rsp_q, res;
	logic      rsp_valid_q;
	logic [CW-1:0] cnt_q;
	logic      accept, fire;

	slot_t                rd_slot, cur_slot, n_slot;
	logic [ID_BITS-1:0]   rd_owner, rd_wpid, rd_wtid;
	logic [ID_BITS-1:0]   n_owner, n_wpid, n_wtid;
	logic [WORD_W-1:0]    rd_pend, n_pend;
	logic signed [ID_BITS-1:0] rd_sender;
	logic [CMP_W-1:0]     ep_w;
	logic                 in_range, alloc, tid_pos;
	logic                 ent_wr, msg_wr, cnt_inc;
	logic [EP_W-1:0]      wr_addr;

	// entry layout: state, owner, waiting pid, waiting tid, pending bits
	assign rd_slot   = slot_t'(ent_rdata[WORD_W+3*ID_BITS +: 2]);
	assign rd_owner  = ent_rdata[WORD_W+2*ID_BITS +: ID_BITS];
	assign rd_wpid   = ent_rdata[WORD_W+ID_BITS +: ID_BITS];
	assign rd_wtid   = ent_rdata[WORD_W +: ID_BITS];
	assign rd_pend   = ent_rdata[WORD_W-1:0];
	assign rd_sender = msg_rdata[4*WORD_W +: ID_BITS];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (fire) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != FSM_IDLE);
		accept    = req_valid && (state_q == FSM_IDLE);
		fire      = (state_q == FSM_EXEC) && (!rsp_valid_q || !rsp_stall);
	end

	always_comb begin
		ep_w     = {1'b0, req_s1.endpoint};
		in_range = ep_w < CMP_W'(NUM_ENDPOINTS);
		alloc    = ep_w < CMP_W'(cnt_q);
		cur_slot = alloc ? rd_slot : SLOT_FREE;
		tid_pos  = (rd_wtid != '0) && !rd_wtid[ID_BITS-1];
		n_slot   = cur_slot;
		n_owner  = rd_owner;
		n_wpid   = rd_wpid;
		n_wtid   = rd_wtid;
		n_pend   = rd_pend;
		wr_addr  = req_s1.endpoint;
		ent_wr   = 1'b0;
		msg_wr   = 1'b0;
		cnt_inc  = 1'b0;
		res        = '0;
		res.status = STAT_ERR;
		if (req_s1.command == CMD_CREATE) begin
			// entries are never released, so the free ones are those at or above the count
			if (cnt_q < CW'(NUM_ENDPOINTS)) begin
				n_slot  = SLOT_IDLE;
				n_owner = ID_BITS'(req_s1.owner_id);
				n_wpid  = '1;
				n_wtid  = '1;
				n_pend  = '0;
				wr_addr = EP_W'(cnt_q);
				ent_wr  = 1'b1;
				cnt_inc = 1'b1;
				res.status       = STAT_OK;
				res.new_endpoint = EP_W'(cnt_q);
			end
		end else if (in_range && cur_slot != SLOT_FREE) begin
			unique case (req_s1.command)
				CMD_SEND: begin
					msg_wr     = 1'b1;
					ent_wr     = 1'b1;
					res.status = STAT_OK;
					if (cur_slot == SLOT_RECV_WAIT) begin
						n_slot = SLOT_IDLE;
						n_wpid = '1;
						if (tid_pos) begin
							res.wake_valid = 1'b1;
							res.wake_tid   = PID_W'(rd_wtid);
							n_wtid         = '1;
						end
					end else begin
						n_slot = SLOT_SEND_WAIT;
						n_wpid = ID_BITS'(req_s1.caller_pid);
					end
				end
				CMD_RECV, CMD_TRY_RECV: begin
					if (rd_pend != '0) begin
						res.status     = STAT_OK;
						res.out_word0  = rd_pend;
						res.out_sender = '1;
						n_pend         = '0;
						ent_wr         = 1'b1;
					end else if (cur_slot == SLOT_SEND_WAIT) begin
						res.status     = STAT_OK;
						res.out_word0  = msg_rdata[0 +: WORD_W];
						res.out_word1  = msg_rdata[WORD_W +: WORD_W];
						res.out_word2  = msg_rdata[2*WORD_W +: WORD_W];
						res.out_word3  = msg_rdata[3*WORD_W +: WORD_W];
						res.out_sender = SID_W'(rd_sender);
						n_slot         = SLOT_IDLE;
						n_wpid         = '1;
						ent_wr         = 1'b1;
					end else if (req_s1.command == CMD_RECV) begin
						res.status = STAT_BLOCK;
						n_slot     = SLOT_RECV_WAIT;
						n_wpid     = ID_BITS'(req_s1.caller_pid);
						n_wtid     = ID_BITS'(req_s1.caller_tid);
						ent_wr     = 1'b1;
					end
				end
				CMD_NOTIFY: begin
					res.status = STAT_OK;
					n_pend     = rd_pend | req_s1.notify_bits;
					ent_wr     = 1'b1;
					if (cur_slot == SLOT_RECV_WAIT) begin
						n_slot = SLOT_IDLE;
						n_wpid = '1;
						if (tid_pos) begin
							res.wake_valid = 1'b1;
							res.wake_tid   = PID_W'(rd_wtid);
							n_wtid         = '1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		mc.re     = accept;
		mc.ent_we = fire && ent_wr;
		mc.msg_we = fire && msg_wr;
		mc.addr   = accept ? req.endpoint : wr_addr;
		ent_wdata = {n_slot, n_owner, n_wpid, n_wtid, n_pend};
		msg_wdata = {ID_BITS'(req_s1.msg_sender), req_s1.msg_word3, req_s1.msg_word2,
			req_s1.msg_word1, req_s1.msg_word0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (fire && cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`IEM_ASSERT(a_cnt_bound, cnt_q <= CW'(NUM_ENDPOINTS))
	`IEM_ASSERT(a_no_rw_overlap, mc.re |-> !(mc.ent_we || mc.msg_we))
	`IEM_ASSERT(a_accept_exec, accept |=> state_q == FSM_EXEC)
	`IEM_ASSERT(a_rsp_from_exec, $rose(rsp_valid_q) |-> $past(state_q == FSM_EXEC))
	`IEM_ASSERT_MSG(a_wake_ok, (rsp_valid_q && rsp_q.wake_valid) |-> rsp_q.status == STAT_OK, "wake without ok status")

endmodule

>>> sv/ipc_endpoint_mailbox_top.sv
`timescale 1ns / 1ps
// An item is accepted together with its entry and message read; the execute state then computes its
// result into the output register once that register is free. Items are handled one at a time
// (accept plus entry read, then modify and write back) on the single-port entry and message memories.
// The next item is taken while a result waits in the output register.
// Reset: asynchronous, clears the control state and the claimed-entry count; no memory sweep.
module ipc_endpoint_mailbox_top import ipc_ep_pkg::*; #(
	parameter int NUM_ENDPOINTS = 64,
	parameter int ID_BITS       = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	localparam int AW    = $clog2(NUM_ENDPOINTS);
	localparam int ENT_W = 2 + 3 * ID_BITS + WORD_W;
	localparam int MSG_W = 4 * WORD_W + ID_BITS;

	mem_ctl_t         mc;
	logic [ENT_W-1:0] ent_wdata, ent_rdata;
	logic [MSG_W-1:0] msg_wdata, msg_rdata;

	ipc_ep_ctrl #(
		.NUM_ENDPOINTS(NUM_ENDPOINTS),
		.ID_BITS(ID_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.mc(mc),
		.ent_wdata(ent_wdata),
		.ent_rdata(ent_rdata),
		.msg_wdata(msg_wdata),
		.msg_rdata(msg_rdata)
	);

	ipc_ep_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NUM_ENDPOINTS)
	) u_ent_ram (
		.clk(clk),
		.re(mc.re),
		.we(mc.ent_we),
		.addr(mc.addr[AW-1:0]),
		.wdata(ent_wdata),
		.rdata(ent_rdata)
	);

	ipc_ep_ram #(
		.WIDTH(MSG_W),
		.DEPTH(NUM_ENDPOINTS)
	) u_msg_ram (
		.clk(clk),
		.re(mc.re),
		.we(mc.msg_we),
		.addr(mc.addr[AW-1:0]),
		.wdata(msg_wdata),
		.rdata(msg_rdata)
	);

endmodule
